// ===== hdl/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg: shared constants and types for the ordered list engine
// Opcodes, status codes and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package ole_pkg;
	localparam int LIST_CAPACITY = 16;
	localparam int AW = $clog2(LIST_CAPACITY);
	localparam int CW = $clog2(LIST_CAPACITY + 1);

	localparam logic [3:0] OP_APPEND   = 4'd0;
	localparam logic [3:0] OP_PREPEND  = 4'd1;
	localparam logic [3:0] OP_INSERT   = 4'd2;
	localparam logic [3:0] OP_CONTAINS = 4'd3;
	localparam logic [3:0] OP_STATUS   = 4'd4;
	localparam logic [3:0] OP_GET      = 4'd5;
	localparam logic [3:0] OP_INDEX_OF = 4'd6;
	localparam logic [3:0] OP_RM_FIRST = 4'd7;
	localparam logic [3:0] OP_RM_LAST  = 4'd8;
	localparam logic [3:0] OP_RM_AT    = 4'd9;
	localparam logic [3:0] OP_REVERSE  = 4'd10;
	localparam logic [3:0] OP_SORT     = 4'd11;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADPOS   = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	// memory port command from controller
	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [1:0]    wr_sel;   // 0 input value, 1 read data, 2 held word
		logic          hold_ld;  // capture read data into held word
	} ole_cmd_t;

	localparam logic [1:0] WS_VALUE = 2'd0;
	localparam logic [1:0] WS_RDATA = 2'd1;
	localparam logic [1:0] WS_HOLD  = 2'd2;

	typedef struct packed {
		logic        eq;       // read data equals input value
		logic        gt;       // held word greater than read data (signed)
		logic [31:0] rdata;
	} ole_stat_t;
endpackage

// ===== hdl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine: bounded ordered list of signed 32-bit values
// Requests on the in channel (opcode, value, position), one result beat
// per request on the out channel (status, result_value, result_index,
// element_count, is_empty). Both channels use valid/ready.
// One request is in flight at a time: in_ready is low from acceptance
// until the result beat is taken. Request time is set by the single
// memory port walking the list: searches read elements in turn until
// a match; append/prepend/insert shift the elements from the insert
// position up; remove shifts later elements down (rm_last only
// shrinks the count); reverse swaps pairs from both ends; sort runs a
// compare-swap loop over every pair.
// Reset empties the list (count to zero); element storage is not cleared.
// A stalled out_ready holds the result beat and blocks new requests.
// ----------------------------------------------------------------------------
module ordered_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [31:0] value,
	input  logic [7:0]  position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] result_value,
	output logic [3:0]  result_index,
	output logic [4:0]  element_count,
	output logic        is_empty
);
	import ole_pkg::*;

	ole_cmd_t    cmd;
	ole_stat_t   stat;
	logic [31:0] value_q;

	ole_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .value, .position,
		.out_valid, .out_ready, .status, .result_value, .result_index,
		.element_count, .is_empty, .cmd, .stat, .value_q
	);

	ole_datapath u_dp (
		.clk, .cmd, .value_q, .stat
	);
endmodule

// ===== hdl/ole_datapath.sv =====
// ----------------------------------------------------------------------------
// ole_datapath: element memory, held word and compare logic
// One write and one registered read per cycle under controller command.
// ----------------------------------------------------------------------------
module ole_datapath (
	input  logic               clk,
	input  ole_pkg::ole_cmd_t  cmd,
	input  logic [31:0]        value_q,
	output ole_pkg::ole_stat_t stat
);
	import ole_pkg::*;

	logic [31:0] mem [LIST_CAPACITY];
	logic [31:0] rdata_q;
	logic [31:0] hold_q;
	logic [31:0] wdata;

	// select write data
	always_comb begin
		case (cmd.wr_sel)
			WS_VALUE: wdata = value_q;
			WS_RDATA: wdata = rdata_q;
			WS_HOLD:  wdata = hold_q;
			default:  wdata = value_q;
		endcase
	end

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[cmd.wr_addr] <= wdata;
		if (cmd.rd_en) rdata_q <= mem[cmd.rd_addr];
	end

	// capture a word for swaps
	always_ff @(posedge clk) begin
		if (cmd.hold_ld) hold_q <= rdata_q;
	end

	assign stat.eq    = (rdata_q == value_q);
	assign stat.gt    = ($signed(hold_q) > $signed(rdata_q));
	assign stat.rdata = rdata_q;
endmodule

// ===== hdl/ole_ctrl.sv =====
// ----------------------------------------------------------------------------
// ole_ctrl: request sequencer
// Decodes each request, walks the memory for shifts, searches, reverse and
// sort, and builds the result beat.
// ----------------------------------------------------------------------------
module ole_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [3:0]          opcode,
	input  logic [31:0]         value,
	input  logic [7:0]          position,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [31:0]         result_value,
	output logic [3:0]          result_index,
	output logic [4:0]          element_count,
	output logic                is_empty,
	output ole_pkg::ole_cmd_t   cmd,
	input  ole_pkg::ole_stat_t  stat,
	output logic [31:0]         value_q
);
	import ole_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_SHR   = 4'd2;  // read i-1, then write i
	localparam logic [3:0] S_SHRW  = 4'd3;
	localparam logic [3:0] S_SHL   = 4'd4;  // read i+1, then write i
	localparam logic [3:0] S_SHLW  = 4'd5;
	localparam logic [3:0] S_SRCH  = 4'd6;
	localparam logic [3:0] S_SRCHW = 4'd7;
	localparam logic [3:0] S_GETW  = 4'd8;
	localparam logic [3:0] S_SWRA  = 4'd9;  // read a
	localparam logic [3:0] S_SWRB  = 4'd10; // hold a, read b
	localparam logic [3:0] S_SWCMP = 4'd11; // b in rdata, a in hold
	localparam logic [3:0] S_SWWB  = 4'd12; // write a to j (already wrote b to i)
	localparam logic [3:0] S_OUT   = 4'd13;

	logic [3:0]    state_q;
	logic [3:0]    op_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q, j_q;
	logic          sort_q;
	logic [2:0]    st_q;
	logic [31:0]   rval_q;
	logic [AW-1:0] ridx_q;

	logic [CW-1:0] pos_ext;
	assign pos_ext = (position > 8'(LIST_CAPACITY)) ? CW'(LIST_CAPACITY + 1 > (1 << CW) - 1 ?
		(1 << CW) - 1 : LIST_CAPACITY + 1) : CW'(position);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status        = st_q;
	assign result_value  = rval_q;
	assign result_index  = 4'(ridx_q);
	assign element_count = 5'(cnt_q);
	assign is_empty      = (cnt_q == '0);

	logic full, empty;
	assign full  = (cnt_q == CW'(LIST_CAPACITY));
	assign empty = (cnt_q == '0);

	// memory command decode
	always_comb begin
		cmd = '0;
		case (state_q)
			S_SHR: begin
				if (i_q != pos_q) begin
					cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_q - 1'b1);
				end
			end
			S_SHRW: begin
				cmd.wr_en = 1'b1; cmd.wr_addr = AW'(i_q); cmd.wr_sel = WS_RDATA;
			end
			S_SHL: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_q + 1'b1);
			end
			S_SHLW: begin
				cmd.wr_en = 1'b1; cmd.wr_addr = AW'(i_q); cmd.wr_sel = WS_RDATA;
			end
			S_SRCH:  begin cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_q); end
			S_DEC: begin
				cmd.rd_en = 1'b1; cmd.rd_addr = AW'(pos_q);
			end
			S_SWRA: begin cmd.rd_en = 1'b1; cmd.rd_addr = AW'(i_q); end
			S_SWRB: begin
				cmd.hold_ld = 1'b1; cmd.rd_en = 1'b1; cmd.rd_addr = AW'(j_q);
			end
			S_SWCMP: begin
				if (!sort_q || stat.gt) begin
					cmd.wr_en = 1'b1; cmd.wr_addr = AW'(i_q); cmd.wr_sel = WS_RDATA;
				end
			end
			S_SWWB: begin
				cmd.wr_en = 1'b1; cmd.wr_addr = AW'(j_q); cmd.wr_sel = WS_HOLD;
			end
			default: ;
		endcase
		if (state_q == S_SHR && i_q == pos_q) begin
			cmd.wr_en = 1'b1; cmd.wr_addr = AW'(pos_q); cmd.wr_sel = WS_VALUE;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						value_q <= value;
						pos_q   <= pos_ext;
						st_q    <= ST_OK;
						rval_q  <= '0;
						ridx_q  <= '0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_OUT;
					case (op_q)
						OP_APPEND, OP_PREPEND, OP_INSERT: begin
							if (full) st_q <= ST_FULL;
							else if (op_q == OP_INSERT && !empty && pos_q > cnt_q)
								st_q <= ST_BADPOS;
							else begin
								if (op_q == OP_APPEND) pos_q <= cnt_q;
								else if (op_q == OP_PREPEND || empty) pos_q <= '0;
								i_q <= cnt_q;
								state_q <= S_SHR;
							end
						end
						OP_CONTAINS, OP_INDEX_OF: begin
							if (empty) st_q <= ST_NOTFOUND;
							else begin i_q <= '0; state_q <= S_SRCH; end
						end
						OP_GET: begin
							if (empty) st_q <= ST_EMPTY;
							else if (pos_q >= cnt_q) st_q <= ST_BADPOS;
							else state_q <= S_GETW;
						end
						OP_RM_FIRST, OP_RM_LAST, OP_RM_AT: begin
							if (empty) st_q <= ST_EMPTY;
							else if (op_q == OP_RM_AT && pos_q >= cnt_q) st_q <= ST_BADPOS;
							else if (op_q == OP_RM_LAST) cnt_q <= cnt_q - 1'b1;
							else begin
								i_q <= (op_q == OP_RM_FIRST) ? '0 : pos_q;
								state_q <= S_SHL;
							end
						end
						OP_REVERSE, OP_SORT: begin
							if (cnt_q > CW'(1)) begin
								sort_q <= (op_q == OP_SORT);
								i_q <= '0;
								j_q <= (op_q == OP_SORT) ? CW'(1) : cnt_q - 1'b1;
								state_q <= S_SWRA;
							end
						end
						default: ;
					endcase
				end
				// shift up toward pos, then drop value in
				S_SHR: begin
					if (i_q == pos_q) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_OUT;
					end else state_q <= S_SHRW;
				end
				S_SHRW: begin
					i_q <= i_q - 1'b1;
					state_q <= S_SHR;
				end
				// shift down from i, then shrink
				S_SHL: begin
					if (i_q + 1'b1 >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= S_OUT;
					end else state_q <= S_SHLW;
				end
				S_SHLW: begin
					i_q <= i_q + 1'b1;
					state_q <= S_SHL;
				end
				S_SRCH: state_q <= S_SRCHW;
				S_SRCHW: begin
					if (stat.eq) begin
						ridx_q <= AW'(i_q);
						state_q <= S_OUT;
					end else if (i_q + 1'b1 >= cnt_q) begin
						st_q <= ST_NOTFOUND;
						state_q <= S_OUT;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_SRCH;
					end
				end
				S_GETW: begin
					rval_q <= stat.rdata;
					state_q <= S_OUT;
				end
				S_SWRA:  state_q <= S_SWRB;
				S_SWRB:  state_q <= S_SWCMP;
				S_SWCMP: begin
					if (!sort_q || stat.gt) state_q <= S_SWWB;
					else state_q <= S_SWWB; // overridden below: no swap, so no write back of a to j
					if (sort_q && !stat.gt) begin
						// no swap: advance directly
						if (j_q + 1'b1 < cnt_q) begin
							j_q <= j_q + 1'b1;
							state_q <= S_SWRA;
						end else if (i_q + CW'(2) < cnt_q) begin
							i_q <= i_q + 1'b1;
							j_q <= i_q + CW'(2);
							state_q <= S_SWRA;
						end else state_q <= S_OUT;
					end
				end
				S_SWWB: begin
					if (!sort_q) begin
						if (i_q + CW'(2) < j_q) begin
							i_q <= i_q + 1'b1;
							j_q <= j_q - 1'b1;
							state_q <= S_SWRA;
						end else state_q <= S_OUT;
					end else if (j_q + 1'b1 < cnt_q) begin
						j_q <= j_q + 1'b1;
						state_q <= S_SWRA;
					end else if (i_q + CW'(2) < cnt_q) begin
						i_q <= i_q + 1'b1;
						j_q <= i_q + CW'(2);
						state_q <= S_SWRA;
					end else state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(LIST_CAPACITY)) else $error("count over capacity");
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_full_st: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && st_q == ST_FULL) |-> cnt_q == CW'(LIST_CAPACITY))
		else $error("full status with room");
	a_empty_st: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && st_q == ST_EMPTY) |-> cnt_q == '0) else $error("empty status");
`endif
endmodule
